/* rtl/xor_distance_bucket_table_macros.svh */
// Assertion macros for the bucket table checker
`ifndef XOR_DISTANCE_BUCKET_TABLE_MACROS_SVH
`define XOR_DISTANCE_BUCKET_TABLE_MACROS_SVH
// same-cycle implication, sampled on clk_i, off during reset
`define XDBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bucket table check failed");
// next-cycle implication
`define XDBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bucket table check failed");
`endif

/* rtl/xdbt_pkg.sv */
// Types, constants and helpers shared by the bucket table modules
`timescale 1ns / 1ps
package xdbt_pkg;
  localparam int IdBits     = 64;
  localparam int BucketSize = 8;
  localparam int Buckets    = 64;
  localparam int MaxFound   = 16;
  localparam int Slots      = Buckets * BucketSize;
  localparam int BktW       = $clog2(Buckets);
  localparam int SlotW      = (BucketSize > 1) ? $clog2(BucketSize) : 1;
  localparam int FillW      = $clog2(BucketSize + 1);
  localparam int AddrW      = $clog2(Slots);
  localparam int TotW       = 10;
  localparam int CntW       = 5;
  localparam int QDepth     = 2;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int CfgIdxW    = 1;

  localparam logic [63:0] IdMask = (IdBits >= 64) ? {64{1'b1}}
                                                  : ((64'd1 << IdBits) - 64'd1);
  localparam logic [CfgIdxW-1:0] CfgLocalId   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFailLimit = 1'b1;

  typedef enum logic [1:0] {
    CmdAdd    = 2'd0,
    CmdRemove = 2'd1,
    CmdMark   = 2'd2,
    CmdFind   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    StNew       = 4'd0,
    StRefreshed = 4'd1,
    StReplaced  = 4'd2,
    StSelf      = 4'd3,
    StFull      = 4'd4,
    StRemoved   = 4'd5,
    StAbsent    = 4'd6,
    StCounted   = 4'd7,
    StEvicted   = 4'd8,
    StFound     = 4'd9,
    StNone      = 4'd10
  } status_e;

  typedef struct packed {
    logic [63:0] id;
    logic [31:0] ip;
    logic [15:0] port;
    logic [3:0]  fail;
  } entry_t;

  typedef struct packed {
    cmd_e            cmd;
    logic [63:0]     id;
    logic [31:0]     ip;
    logic [15:0]     port;
    logic [CntW-1:0] want;
    logic [BktW-1:0] bucket;
    logic            self;
  } cmd_item_t;

  function automatic logic [AddrW-1:0] ent_addr(logic [BktW-1:0] bkt,
                                                logic [SlotW-1:0] slot);
    ent_addr = AddrW'(int'(bkt) * BucketSize + int'(slot));
  endfunction

  function automatic logic [BktW-1:0] bucket_of(logic [63:0] x);
    int p;
    p = 0;
    for (int i = 1; i < 64; i++) begin
      if (x[i]) p = i;
    end
    if (p >= Buckets) p = Buckets - 1;
    bucket_of = BktW'(p);
  endfunction
endpackage

/* rtl/xdbt_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module xdbt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

/* rtl/xdbt_front.sv */
// Command intake: masks ids, picks the bucket and queues the word
`timescale 1ns / 1ps
module xdbt_front import xdbt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] node_id_i,
  input  logic [31:0] node_ip_i,
  input  logic [15:0] node_port_i,
  input  logic [4:0]  result_count_i,
  input  logic [63:0] local_id_i,
  output logic        q_valid_o,
  output cmd_item_t   q_item_o,
  input  logic        q_pop_i
);
  cmd_item_t             q_mem [QDepth];
  logic [QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]        cnt_q;
  cmd_item_t             item;
  logic [63:0]           id_m, x;
  logic                  push;

  always_comb begin
    id_m        = node_id_i & IdMask;
    x           = id_m ^ (local_id_i & IdMask);
    item.cmd    = cmd_e'(command_i);
    item.id     = id_m;
    item.ip     = node_ip_i;
    item.port   = node_port_i;
    item.want   = (result_count_i > CntW'(MaxFound)) ? CntW'(MaxFound) : result_count_i;
    item.bucket = bucket_of(x);
    item.self   = (x == '0);
  end

  assign busy_o    = (cnt_q == (QPtrW+1)'(QDepth));
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (q_pop_i) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      cnt_q <= cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(q_pop_i);
    end
  end
endmodule

/* rtl/xdbt_back.sv */
// Command execution: bucket search, slot shifting and nearest-entry scans
`timescale 1ns / 1ps
module xdbt_back import xdbt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        fail_limit_i,
  input  logic              q_valid_i,
  input  cmd_item_t         q_item_i,
  output logic              q_pop_o,
  output logic              result_valid_o,
  output logic [3:0]        status_o,
  output logic [63:0]       entry_id_o,
  output logic [31:0]       entry_ip_o,
  output logic [15:0]       entry_port_o,
  output logic              ping_valid_o,
  output logic [63:0]       ping_id_o,
  output logic [TotW-1:0]   total_nodes_o,
  output logic              last_o
);
  typedef enum logic [12:0] {
    SIdle   = 13'b0000000000001,
    SFill   = 13'b0000000000010,
    SSrch   = 13'b0000000000100,
    SDecide = 13'b0000000001000,
    SShRd   = 13'b0000000010000,
    SShWr   = 13'b0000000100000,
    SFinish = 13'b0000001000000,
    SFInit  = 13'b0000010000000,
    SFBrd   = 13'b0000100000000,
    SFBwt   = 13'b0001000000000,
    SFEnt   = 13'b0010000000000,
    SFEnd   = 13'b0100000000000,
    SFLast  = 13'b1000000000000
  } state_e;

  state_e            state_q, state_d;
  cmd_item_t         cur_q;
  logic [FillW-1:0]  n_q;
  logic [SlotW-1:0]  t_q, s_q, j_q, wr_slot_q;
  logic              found_q, have_prev_q, pend_v_q, wr_en_q, fvld_q;
  entry_t            ent_q, head_q, wr_data_q, best_ent_q, pend_q;
  status_e           st_q;
  logic              ping_q;
  logic [FillW-1:0]  fill_new_q;
  logic [TotW-1:0]   total_q, total_new_q;
  logic [BktW-1:0]   k_q;
  logic [63:0]       best_q, prev_q;
  logic [CntW-1:0]   got_q;
  logic [Buckets-1:0] fill_vld_q;

  logic [AddrW-1:0]  e_raddr, e_waddr;
  logic              e_we;
  entry_t            e_wdata, e_rdata;
  logic [BktW-1:0]   f_raddr;
  logic              f_we;
  logic [FillW-1:0]  f_rraw, n_rd;

  logic              emit;
  status_e           em_st;
  entry_t            em_ent;
  logic              em_ping, em_last;
  logic [63:0]       em_pid;
  logic [TotW-1:0]   em_tot;

  logic              more_t, more_j, d_ok;
  logic [63:0]       d;
  logic [3:0]        f_inc;

  xdbt_ram #(.Width($bits(entry_t)), .Depth(Slots)) u_ent_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  xdbt_ram #(.Width(FillW), .Depth(Buckets)) u_fill_ram (
    .clk_i, .we_i(f_we), .waddr_i(cur_q.bucket), .wdata_i(fill_new_q),
    .raddr_i(f_raddr), .rdata_o(f_rraw)
  );

  assign n_rd   = fvld_q ? f_rraw : '0;
  assign more_t = (FillW'(t_q) + FillW'(1)) < n_q;
  assign more_j = (FillW'(j_q) + FillW'(1)) < n_q;
  assign d      = e_rdata.id ^ cur_q.id;
  assign d_ok   = (!have_prev_q || d > prev_q) && (!found_q || d < best_q);
  assign f_inc  = (ent_q.fail == 4'hF) ? 4'hF : ent_q.fail + 4'd1;
  assign q_pop_o = (state_q == SIdle) && q_valid_i;
  assign f_we    = (state_q == SFinish);

  always_comb begin
    f_raddr = (state_q == SIdle) ? q_item_i.bucket : k_q;
    e_raddr = '0;
    e_we    = 1'b0;
    e_waddr = ent_addr(cur_q.bucket, wr_slot_q);
    e_wdata = wr_data_q;
    case (state_q)
      SFill:   e_raddr = ent_addr(cur_q.bucket, '0);
      SSrch:   e_raddr = ent_addr(cur_q.bucket, t_q + SlotW'(1));
      SShRd:   e_raddr = ent_addr(cur_q.bucket, j_q + SlotW'(1));
      SShWr: begin
        e_we    = 1'b1;
        e_waddr = ent_addr(cur_q.bucket, j_q);
        e_wdata = e_rdata;
      end
      SFinish: e_we = wr_en_q;
      SFBwt:   e_raddr = ent_addr(k_q, '0);
      SFEnt:   e_raddr = ent_addr(k_q, t_q + SlotW'(1));
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    emit    = 1'b0;
    em_st   = StNone;
    em_ent  = '0;
    em_ping = 1'b0;
    em_pid  = '0;
    em_last = 1'b1;
    em_tot  = total_q;
    case (state_q)
      SIdle: begin
        if (q_valid_i) begin
          if (q_item_i.cmd == CmdFind) begin
            state_d = SFInit;
          end else if (q_item_i.self) begin
            emit  = 1'b1;
            em_st = (q_item_i.cmd == CmdAdd) ? StSelf : StAbsent;
          end else begin
            state_d = SFill;
          end
        end
      end
      SFill:   state_d = (n_rd == '0) ? SDecide : SSrch;
      SSrch:   if (!more_t) state_d = SDecide;
      SDecide: state_d = SShRd;
      SShRd:   state_d = more_j ? SShWr : SFinish;
      SShWr:   state_d = SShRd;
      SFinish: begin
        emit    = 1'b1;
        em_st   = st_q;
        em_ping = ping_q;
        em_pid  = ping_q ? head_q.id : '0;
        em_tot  = total_new_q;
        state_d = SIdle;
      end
      SFInit: begin
        if (cur_q.want == '0) begin
          emit    = 1'b1;
          state_d = SIdle;
        end else begin
          state_d = SFBrd;
        end
      end
      SFBrd: state_d = SFBwt;
      SFBwt: begin
        if (n_rd != '0) state_d = SFEnt;
        else if (k_q == BktW'(Buckets - 1)) state_d = SFEnd;
        else state_d = SFBrd;
      end
      SFEnt: begin
        if (!more_t) state_d = (k_q == BktW'(Buckets - 1)) ? SFEnd : SFBrd;
      end
      SFEnd: begin
        if (found_q) begin
          emit    = pend_v_q;
          em_st   = StFound;
          em_ent  = pend_q;
          em_last = 1'b0;
          state_d = ((got_q + CntW'(1)) == cur_q.want) ? SFLast : SFBrd;
        end else begin
          emit    = 1'b1;
          em_st   = pend_v_q ? StFound : StNone;
          em_ent  = pend_v_q ? pend_q : '0;
          state_d = SIdle;
        end
      end
      SFLast: begin
        emit    = 1'b1;
        em_st   = StFound;
        em_ent  = pend_q;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= SIdle;
      total_q        <= '0;
      fill_vld_q     <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= emit;
      if (state_q == SFinish) begin
        total_q                  <= total_new_q;
        fill_vld_q[cur_q.bucket] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fvld_q <= fill_vld_q[f_raddr];
    if (emit) begin
      status_o      <= em_st;
      entry_id_o    <= em_ent.id;
      entry_ip_o    <= em_ent.ip;
      entry_port_o  <= em_ent.port;
      ping_valid_o  <= em_ping;
      ping_id_o     <= em_pid;
      total_nodes_o <= em_tot;
      last_o        <= em_last;
    end
    case (state_q)
      SIdle: if (q_pop_o) cur_q <= q_item_i;
      SFill: begin
        n_q     <= n_rd;
        t_q     <= '0;
        found_q <= 1'b0;
      end
      SSrch: begin
        if (t_q == '0) head_q <= e_rdata;
        if (e_rdata.id == cur_q.id && !found_q) begin
          found_q <= 1'b1;
          s_q     <= t_q;
          ent_q   <= e_rdata;
        end
        t_q <= t_q + SlotW'(1);
      end
      SDecide: begin
        wr_en_q     <= 1'b0;
        ping_q      <= 1'b0;
        fill_new_q  <= n_q;
        total_new_q <= total_q;
        wr_data_q   <= '{id: cur_q.id, ip: cur_q.ip, port: cur_q.port, fail: 4'd0};
        wr_slot_q   <= SlotW'(n_q - FillW'(1));
        j_q         <= s_q;
        st_q        <= StAbsent;
        n_q         <= '0;
        case (cur_q.cmd)
          CmdAdd: begin
            n_q <= n_q;
            if (found_q) begin
              st_q    <= StRefreshed;
              wr_en_q <= 1'b1;
            end else if (n_q < FillW'(BucketSize)) begin
              st_q        <= StNew;
              wr_en_q     <= 1'b1;
              wr_slot_q   <= SlotW'(n_q);
              fill_new_q  <= n_q + FillW'(1);
              total_new_q <= total_q + TotW'(1);
              n_q         <= '0;
            end else if (head_q.fail != '0) begin
              st_q    <= StReplaced;
              wr_en_q <= 1'b1;
              j_q     <= '0;
            end else begin
              st_q   <= StFull;
              ping_q <= 1'b1;
              n_q    <= '0;
            end
          end
          CmdRemove: begin
            if (found_q) begin
              st_q        <= StRemoved;
              n_q         <= n_q;
              fill_new_q  <= n_q - FillW'(1);
              total_new_q <= total_q - TotW'(1);
            end
          end
          default: begin
            if (found_q) begin
              if (f_inc >= fail_limit_i) begin
                st_q        <= StEvicted;
                n_q         <= n_q;
                fill_new_q  <= n_q - FillW'(1);
                total_new_q <= total_q - TotW'(1);
              end else begin
                st_q      <= StCounted;
                wr_en_q   <= 1'b1;
                wr_slot_q <= s_q;
                wr_data_q <= '{id: ent_q.id, ip: ent_q.ip, port: ent_q.port, fail: f_inc};
              end
            end
          end
        endcase
      end
      SShWr: j_q <= j_q + SlotW'(1);
      SFInit: begin
        got_q       <= '0;
        have_prev_q <= 1'b0;
        pend_v_q    <= 1'b0;
        found_q     <= 1'b0;
        k_q         <= '0;
      end
      SFBwt: begin
        n_q <= n_rd;
        t_q <= '0;
        if (n_rd == '0) k_q <= k_q + BktW'(1);
      end
      SFEnt: begin
        if (d_ok) begin
          found_q    <= 1'b1;
          best_q     <= d;
          best_ent_q <= e_rdata;
        end
        t_q <= t_q + SlotW'(1);
        if (!more_t) k_q <= k_q + BktW'(1);
      end
      SFEnd: begin
        if (found_q) begin
          pend_q      <= best_ent_q;
          pend_v_q    <= 1'b1;
          prev_q      <= best_q;
          have_prev_q <= 1'b1;
          got_q       <= got_q + CntW'(1);
          found_q     <= 1'b0;
          k_q         <= '0;
        end
      end
      default: ;
    endcase
  end
endmodule

/* rtl/xor_distance_bucket_table.sv */
// Top level of the XOR-distance bucket table
`timescale 1ns / 1ps
// A command is taken when start_i is high and busy_o low; two commands may wait
// in the intake queue while one executes. Add, remove and mark-failed read the
// addressed bucket's fill, search its slots one slot a cycle, then shift slots
// one place toward the head with a read and a write per shifted slot before
// their one word. Find scans every bucket once per returned entry, up to
// result_count rounds (limited to MAX_FOUND), or stored entries + 1 rounds when
// fewer are held. Each found word leaves at the end of the round after the one
// that found it; the final word leaves directly. Each result word is shown for
// exactly one cycle on result_valid_o and cannot be held off. Entry memory needs
// no clearing after reset; only slots below a bucket's fill are used.
module xor_distance_bucket_table import xdbt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         command_i,
  input  logic [63:0]        node_id_i,
  input  logic [31:0]        node_ip_i,
  input  logic [15:0]        node_port_i,
  input  logic [4:0]         result_count_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic [3:0]         status_o,
  output logic [63:0]        entry_id_o,
  output logic [31:0]        entry_ip_o,
  output logic [15:0]        entry_port_o,
  output logic               ping_valid_o,
  output logic [63:0]        ping_id_o,
  output logic [TotW-1:0]    total_nodes_o,
  output logic               last_o
);
  logic [63:0] local_id_q;
  logic [3:0]  fail_limit_q;
  logic        q_valid, q_pop;
  cmd_item_t   q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_id_q   <= '0;
      fail_limit_q <= 4'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLocalId:   local_id_q   <= cfg_data_i;
        CfgFailLimit: fail_limit_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  xdbt_front u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .node_id_i, .node_ip_i,
    .node_port_i, .result_count_i, .local_id_i(local_id_q),
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  xdbt_back u_back (
    .clk_i, .rst_ni, .fail_limit_i(fail_limit_q), .q_valid_i(q_valid),
    .q_item_i(q_item), .q_pop_o(q_pop), .result_valid_o, .status_o, .entry_id_o,
    .entry_ip_o, .entry_port_o, .ping_valid_o, .ping_id_o, .total_nodes_o, .last_o
  );
endmodule

/* rtl/xdbt_checker.sv */
// Port-level checks of the bucket table and their binding
`timescale 1ns / 1ps
`include "xor_distance_bucket_table_macros.svh"
module xdbt_checker import xdbt_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            result_valid_o,
  input logic [3:0]      status_o,
  input logic [63:0]     entry_id_o,
  input logic            ping_valid_o,
  input logic [63:0]     ping_id_o,
  input logic [TotW-1:0] total_nodes_o,
  input logic            last_o
);
  `XDBT_ASSERT_IMP(a_ping_only_full, result_valid_o && ping_valid_o, status_o == StFull)
  `XDBT_ASSERT_IMP(a_single_word, result_valid_o && status_o != StFound, entry_id_o == '0 && last_o)
  `XDBT_ASSERT_IMP(a_total_range, result_valid_o, total_nodes_o <= TotW'(Slots))
  `XDBT_ASSERT_IMP(a_no_ping_id, result_valid_o && !ping_valid_o, ping_id_o == '0)
endmodule

bind xor_distance_bucket_table xdbt_checker u_xdbt_checker (.*);
